@@ rtl/core/bae_pkg.sv @@
// ----------------------------------------------------------------------------
// bae_pkg
// Shared widths, codes and register addresses of the buddy allocator.
// ----------------------------------------------------------------------------
package bae_pkg;

    // Field widths of the request and response transactions
    localparam int SIZE_W = 16;
    localparam int ID_W   = 32;
    localparam int STAT_W = 2;
    localparam int POS_W  = 12;
    localparam int BSZ_W  = 13;
    localparam int EVC_W  = 9;

    // Block order width (covers every order reachable by the parameter range)
    localparam int ORD_W    = 5;
    // Largest order a 16-bit size can ask for (minimum block of one byte)
    localparam int NEED_MAX = 16;
    localparam int STAMP_W  = 32;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_FIT = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_REP = 3'd4;

    // Request actions
    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Response status codes
    localparam logic [STAT_W-1:0] ST_STORED = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FOUND  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS   = 2'd3;

    // Policies
    localparam logic FP_FIRST = 1'b0;
    localparam logic FP_BEST  = 1'b1;
    localparam logic RP_FIFO  = 1'b0;
    localparam logic RP_LRU   = 1'b1;

endpackage

@@ rtl/core/bae_if.sv @@
// ----------------------------------------------------------------------------
// bae_req_if / bae_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface bae_req_if
    import bae_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [SIZE_W-1:0] message_size;
    logic [ID_W-1:0]   message_id;

    modport source (output valid, action, message_size, message_id, input ready);
    modport sink   (input valid, action, message_size, message_id, output ready);
endinterface

interface bae_rsp_if
    import bae_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [BSZ_W-1:0]  block_size;
    logic [EVC_W-1:0]  evicted_count;

    modport source (output valid, status, position, block_size, evicted_count,
                    input ready);
    modport sink   (input valid, status, position, block_size, evicted_count,
                    output ready);
endinterface

@@ rtl/core/bae_ram.sv @@
// ----------------------------------------------------------------------------
// bae_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/buddy_allocator_with_eviction_unit.sv @@
// Sequence: a lookup answers within one table scan after acceptance; an
// allocation takes a fit scan, plus per eviction owner scans (after a stamp
// scan under LRU), merge passes and another fit scan, then the splits, the
// claim of the block and, oldest-first, the queueing of the id.
// Throughput: one transaction at a time; all table work shares one read port.
// Reset: synchronous, active low; afterwards a clearing pass over every slot
// initializes the block table while the request channel is held not ready.
// ----------------------------------------------------------------------------
// buddy_allocator_with_eviction_unit
// Buddy allocator over a slot table with first/best fit, FIFO/LRU eviction
// and aligned buddy merging, run by a small sequencer over shared RAM ports.
// ----------------------------------------------------------------------------
module buddy_allocator_with_eviction_unit
    import bae_pkg::*;
#(
    parameter int MEM_BYTES = 4096,
    parameter int MIN_BLOCK = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bae_req_if.sink           i_req,
    bae_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);
    localparam int NSLOT  = (MEM_BYTES / MIN_BLOCK) > 0 ? (MEM_BYTES / MIN_BLOCK) : 1;
    localparam int SLOT_W = NSLOT > 1 ? $clog2(NSLOT) : 1;
    localparam int IDX_W  = SLOT_W + 1;
    localparam bit MEM_OK = MIN_BLOCK <= MEM_BYTES;
    localparam int META_W = ORD_W + 2;
    localparam int OS_W   = ID_W + STAMP_W;

    function automatic int f_top_order();
        int t;
        t = 0;
        for (int k = 1; k < 31; k++) begin
            if (((longint'(MIN_BLOCK) << k) <= longint'(MEM_BYTES)) &&
                ((longint'(1) << k) <= longint'(NSLOT))) begin
                t = k;
            end
        end
        return t;
    endfunction

    localparam int TOP_ORDER = f_top_order();
    localparam logic [ORD_W-1:0] TOP = ORD_W'(TOP_ORDER);
    localparam logic [IDX_W-1:0] N_IDX = IDX_W'(NSLOT);

    function automatic logic [POS_W-1:0] f_pos(input logic [SLOT_W-1:0] slot);
        logic [31:0] p;
        p = 32'(slot) * 32'(MIN_BLOCK);
        return p[POS_W-1:0];
    endfunction

    function automatic logic [BSZ_W-1:0] f_bsize(input logic [ORD_W-1:0] ord);
        logic [31:0] b;
        b = 32'(MIN_BLOCK) << ord;
        return b[BSZ_W-1:0];
    endfunction

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_SCAN, S_EVICT, S_EVQ, S_QWAIT, S_MRG, S_M_RS, S_M_WS,
        S_M_WB, S_M_WL, S_SPLIT, S_QPUSH, S_OUT
    } t_state;

    typedef enum logic [1:0] {K_LOOK, K_FIT, K_FREE, K_MIN} t_kind;

    t_state               r_state;
    t_kind                r_kind;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_pv;
    logic [SLOT_W-1:0]    r_pidx;
    logic [ID_W-1:0]      r_id;
    logic [ORD_W-1:0]     r_need;
    logic                 r_have;
    logic [SLOT_W-1:0]    r_slot;
    logic [ORD_W-1:0]     r_cord;
    logic [STAMP_W-1:0]   r_bstamp;
    logic [ID_W-1:0]      r_bown;
    logic [ID_W-1:0]      r_vid;
    logic                 r_fromq;
    logic                 r_freed;
    logic [EVC_W-1:0]     r_evict;
    logic [ORD_W-1:0]     r_k;
    logic [SLOT_W-1:0]    r_bud;
    logic                 r_changed;
    logic [SLOT_W-1:0]    r_qhead;
    logic [IDX_W-1:0]     r_qcount;
    logic [STAMP_W-1:0]   r_use;
    logic                 r_fit;
    logic                 r_rep;
    logic                 r_valid;
    logic [STAT_W-1:0]    r_status;
    logic [POS_W-1:0]     r_pos;
    logic [BSZ_W-1:0]     r_bsize;
    logic [EVC_W-1:0]     r_evc;

    // RAM ports
    logic                 meta_we;
    logic [SLOT_W-1:0]    meta_waddr;
    logic [META_W-1:0]    meta_wdata;
    logic [SLOT_W-1:0]    tbl_raddr;
    logic [META_W-1:0]    meta_rd;
    logic                 os_we;
    logic [OS_W-1:0]      os_wdata;
    logic [OS_W-1:0]      os_rd;
    logic                 q_we;
    logic [SLOT_W-1:0]    q_waddr;
    logic [ID_W-1:0]      q_rd;

    // Decoded table entry
    logic                 m_head;
    logic                 m_free;
    logic [ORD_W-1:0]     m_ord;
    logic [ID_W-1:0]      m_owner;
    logic [STAMP_W-1:0]   m_stamp;
    logic                 w_occ;

    logic [ORD_W-1:0]     w_need;
    logic                 w_reject;
    logic                 w_scan_end;
    logic                 w_look_hit;
    logic                 w_fit_hit;
    logic                 w_free_hit;
    logic                 w_min_hit;
    logic [SLOT_W-1:0]    w_bud;
    logic                 w_bud_ok;
    logic                 w_m_cand;
    logic                 w_m_hit;
    logic [SLOT_W-1:0]    w_lo;
    logic [SLOT_W-1:0]    w_hi;
    logic [ORD_W-1:0]     w_cord_dn;
    logic [SLOT_W-1:0]    w_qh_inc;
    logic [SLOT_W-1:0]    w_qh2;
    logic [IDX_W-1:0]     w_qc2;
    logic [IDX_W-1:0]     w_qsum;
    logic                 w_cfg_wr;

    bae_ram #(.WIDTH(META_W), .DEPTH(NSLOT)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (meta_rd)
    );

    bae_ram #(.WIDTH(OS_W), .DEPTH(NSLOT)) u_owner (
        .i_clk   (i_clk),
        .i_we    (os_we),
        .i_waddr (r_slot),
        .i_wdata (os_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (os_rd)
    );

    bae_ram #(.WIDTH(ID_W), .DEPTH(NSLOT)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (r_id),
        .i_raddr (r_qhead),
        .o_rdata (q_rd)
    );

    assign m_head  = meta_rd[ORD_W+1];
    assign m_free  = meta_rd[ORD_W];
    assign m_ord   = meta_rd[ORD_W-1:0];
    assign m_owner = os_rd[OS_W-1:STAMP_W];
    assign m_stamp = os_rd[STAMP_W-1:0];
    assign w_occ   = m_head & ~m_free;

    // Round the requested size up to a block order
    always_comb begin
        w_need = ORD_W'(NEED_MAX);
        for (int k = NEED_MAX; k >= 0; k--) begin
            if ((32'(MIN_BLOCK) << k) >= 32'(i_req.message_size)) begin
                w_need = ORD_W'(k);
            end
        end
    end

    assign w_reject = (32'(i_req.message_size) > 32'(MEM_BYTES)) || !MEM_OK ||
                      (w_need > TOP);

    // Scan compare terms
    assign w_scan_end = (r_idx == N_IDX) && !r_pv;
    assign w_look_hit = r_pv && w_occ && (m_owner == r_id);
    assign w_fit_hit  = r_pv && m_head && m_free && (m_ord >= r_need);
    assign w_free_hit = r_pv && w_occ && (m_owner == r_vid);
    assign w_min_hit  = r_pv && w_occ && (!r_have || (m_stamp < r_bstamp));

    // Merge terms
    assign w_bud    = r_idx[SLOT_W-1:0] ^ (SLOT_W'(1) << m_ord);
    assign w_bud_ok = IDX_W'(w_bud) < N_IDX;
    assign w_m_cand = m_head && m_free && (m_ord < TOP) && w_bud_ok;
    assign w_m_hit  = m_head && m_free && (m_ord == r_k);
    assign w_lo     = (r_idx[SLOT_W-1:0] < r_bud) ? r_idx[SLOT_W-1:0] : r_bud;
    assign w_hi     = (r_idx[SLOT_W-1:0] < r_bud) ? r_bud : r_idx[SLOT_W-1:0];

    assign w_cord_dn = r_cord - ORD_W'(1);

    // Arrival queue arithmetic, drop the oldest entry when full
    assign w_qh_inc = (IDX_W'(r_qhead) == N_IDX - IDX_W'(1)) ? '0
                                                           : r_qhead + SLOT_W'(1);
    assign w_qh2    = (r_qcount >= N_IDX) ? w_qh_inc : r_qhead;
    assign w_qc2    = (r_qcount >= N_IDX) ? N_IDX - IDX_W'(1) : r_qcount;
    assign w_qsum   = IDX_W'(w_qh2) + w_qc2;

    // Drive RAM ports from the sequencer state
    always_comb begin
        meta_we    = 1'b0;
        meta_waddr = r_pidx;
        meta_wdata = '0;
        tbl_raddr  = r_idx[SLOT_W-1:0];
        os_we      = 1'b0;
        os_wdata   = {r_id, r_use + STAMP_W'(1)};
        q_we       = 1'b0;
        q_waddr    = (w_qsum >= N_IDX) ? SLOT_W'(w_qsum - N_IDX) : SLOT_W'(w_qsum);
        case (r_state)
            S_CLR: begin
                meta_we    = 1'b1;
                meta_waddr = r_idx[SLOT_W-1:0];
                meta_wdata = (r_idx == '0) ? {1'b1, 1'b1, TOP} : {1'b0, 1'b1, ORD_W'(0)};
            end
            S_SCAN: begin
                if (r_kind == K_FREE && w_free_hit) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_pidx;
                    meta_wdata = {1'b1, 1'b1, m_ord};
                end
            end
            S_M_WS: begin
                tbl_raddr = w_bud;
            end
            S_M_WB: begin
                if (w_m_hit) begin
                    meta_we    = 1'b1;
                    meta_waddr = w_hi;
                    meta_wdata = {1'b0, 1'b1, ORD_W'(0)};
                end
            end
            S_M_WL: begin
                meta_we    = 1'b1;
                meta_waddr = w_lo;
                meta_wdata = {1'b1, 1'b1, r_k + ORD_W'(1)};
            end
            S_SPLIT: begin
                meta_we = 1'b1;
                if (r_cord > r_need) begin
                    meta_waddr = r_slot + (SLOT_W'(1) << w_cord_dn);
                    meta_wdata = {1'b1, 1'b1, w_cord_dn};
                end else begin
                    meta_waddr = r_slot;
                    meta_wdata = {1'b1, 1'b0, r_need};
                    os_we      = 1'b1;
                end
            end
            S_QPUSH: begin
                q_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    // Sequencer, configuration registers and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_kind   <= K_LOOK;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_qhead  <= '0;
            r_qcount <= '0;
            r_use    <= '0;
            r_fit    <= FP_FIRST;
            r_rep    <= RP_FIFO;
            r_valid  <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr)
                    ADDR_FIT: r_fit <= pwdata[0];
                    ADDR_REP: r_rep <= pwdata[0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                // Write reset values through the block table
                S_CLR: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == N_IDX - IDX_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_req.valid) begin
                        r_id   <= i_req.message_id;
                        r_need <= w_need;
                        r_idx  <= '0;
                        r_pv   <= 1'b0;
                        r_have <= 1'b0;
                        if (i_req.action == ACT_LOOKUP) begin
                            r_kind  <= K_LOOK;
                            r_state <= S_SCAN;
                        end else if (w_reject) begin
                            r_status <= ST_REJECT;
                            r_pos    <= '0;
                            r_bsize  <= '0;
                            r_evc    <= '0;
                            r_valid  <= 1'b1;
                            r_state  <= S_OUT;
                        end else begin
                            r_evict <= '0;
                            r_kind  <= K_FIT;
                            r_state <= S_SCAN;
                        end
                    end
                end

                // Pipelined pass over the table, one slot issued per cycle
                S_SCAN: begin
                    if (r_idx < N_IDX) begin
                        r_idx  <= r_idx + IDX_W'(1);
                        r_pidx <= r_idx[SLOT_W-1:0];
                        r_pv   <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                    end
                    case (r_kind)
                        K_LOOK: begin
                            if (w_look_hit) begin
                                r_status <= ST_FOUND;
                                r_pos    <= f_pos(r_pidx);
                                r_bsize  <= f_bsize(m_ord);
                                r_evc    <= '0;
                                r_valid  <= 1'b1;
                                r_state  <= S_OUT;
                            end else if (w_scan_end) begin
                                r_status <= ST_MISS;
                                r_pos    <= '0;
                                r_bsize  <= '0;
                                r_evc    <= '0;
                                r_valid  <= 1'b1;
                                r_state  <= S_OUT;
                            end
                        end
                        K_FIT: begin
                            if (w_fit_hit) begin
                                if (r_fit == FP_FIRST) begin
                                    r_slot  <= r_pidx;
                                    r_cord  <= m_ord;
                                    r_state <= S_SPLIT;
                                end else if (!r_have || m_ord < r_cord) begin
                                    r_have <= 1'b1;
                                    r_slot <= r_pidx;
                                    r_cord <= m_ord;
                                end
                            end else if (w_scan_end) begin
                                r_state <= r_have ? S_SPLIT : S_EVICT;
                            end
                        end
                        K_FREE: begin
                            if (w_free_hit) begin
                                r_freed <= 1'b1;
                            end
                            if (w_scan_end) begin
                                r_state <= (r_fromq && !r_freed) ? S_EVQ : S_MRG;
                            end
                        end
                        K_MIN: begin
                            if (w_min_hit) begin
                                r_have   <= 1'b1;
                                r_bstamp <= m_stamp;
                                r_bown   <= m_owner;
                            end else if (w_scan_end) begin
                                if (r_have) begin
                                    r_vid   <= r_bown;
                                    r_fromq <= 1'b0;
                                    r_freed <= 1'b0;
                                    r_kind  <= K_FREE;
                                    r_idx   <= '0;
                                end else begin
                                    r_state <= S_MRG;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                S_EVICT: begin
                    r_evict <= r_evict + EVC_W'(1);
                    r_state <= S_EVQ;
                end

                // Pick the victim source: arrival queue or smallest stamp
                S_EVQ: begin
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                    if (r_rep == RP_FIFO && r_qcount != '0) begin
                        r_state <= S_QWAIT;
                    end else begin
                        r_have  <= 1'b0;
                        r_kind  <= K_MIN;
                        r_state <= S_SCAN;
                    end
                end

                // Pop the oldest id and free its blocks
                S_QWAIT: begin
                    r_vid    <= q_rd;
                    r_qhead  <= w_qh_inc;
                    r_qcount <= r_qcount - IDX_W'(1);
                    r_fromq  <= 1'b1;
                    r_freed  <= 1'b0;
                    r_kind   <= K_FREE;
                    r_state  <= S_SCAN;
                end

                S_MRG: begin
                    r_idx     <= '0;
                    r_changed <= 1'b0;
                    r_state   <= S_M_RS;
                end

                // Merge pass: read slot, read its buddy, write high then low
                S_M_RS: begin
                    if (r_idx == N_IDX) begin
                        if (r_changed) begin
                            r_state <= S_MRG;
                        end else begin
                            r_idx   <= '0;
                            r_pv    <= 1'b0;
                            r_have  <= 1'b0;
                            r_kind  <= K_FIT;
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_state <= S_M_WS;
                    end
                end

                S_M_WS: begin
                    if (w_m_cand) begin
                        r_k     <= m_ord;
                        r_bud   <= w_bud;
                        r_state <= S_M_WB;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_M_RS;
                    end
                end

                S_M_WB: begin
                    if (w_m_hit) begin
                        r_state <= S_M_WL;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_M_RS;
                    end
                end

                S_M_WL: begin
                    r_changed <= 1'b1;
                    r_idx     <= r_idx + IDX_W'(1);
                    r_state   <= S_M_RS;
                end

                // Halve the chosen block until it matches, then claim it
                S_SPLIT: begin
                    if (r_cord > r_need) begin
                        r_cord <= w_cord_dn;
                    end else begin
                        r_use    <= r_use + STAMP_W'(1);
                        r_status <= ST_STORED;
                        r_pos    <= f_pos(r_slot);
                        r_bsize  <= f_bsize(r_need);
                        r_evc    <= r_evict;
                        if (r_rep == RP_FIFO) begin
                            r_state <= S_QPUSH;
                        end else begin
                            r_valid <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end

                S_QPUSH: begin
                    r_qhead  <= w_qh2;
                    r_qcount <= w_qc2 + IDX_W'(1);
                    r_valid  <= 1'b1;
                    r_state  <= S_OUT;
                end

                // Hold the response until taken
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.position      = r_pos;
    assign o_rsp.block_size    = r_bsize;
    assign o_rsp.evicted_count = r_evc;

    // Configuration read back
    always_comb begin
        case (paddr)
            ADDR_FIT: prdata = DATA_W'(r_fit);
            ADDR_REP: prdata = DATA_W'(r_rep);
            default:  prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Checks
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("request ready while a response is pending");

    a_qcount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= N_IDX)
        else $error("arrival queue count exceeds table depth");

    a_empty_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_REJECT || o_rsp.status == ST_MISS))
        |-> (o_rsp.position == '0 && o_rsp.block_size == '0 &&
             o_rsp.evicted_count == '0))
        else $error("reject or miss carries a block");

    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken without starting work");
endmodule
